// File: rtl/stepper_indexer_with_homing_top_defines.svh
`ifndef STEPPER_INDEXER_WITH_HOMING_TOP_DEFINES_SVH
`define STEPPER_INDEXER_WITH_HOMING_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SIHM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define SIHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Condition never holds.
`define SIHM_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("assertion failed");

`endif

// File: rtl/sihm_pkg.sv
package sihm_pkg;

    localparam int KIND_W    = 2;
    localparam int GOAL_W    = 31;
    localparam int DELAY_W   = 16;
    localparam int MAXG_W    = 31;
    localparam int COIL_W    = 4;
    localparam int OUT_POS_W = 32;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [DELAY_W-1:0] DELAY_RST = 16'd100;
    localparam logic [MAXG_W-1:0]  MAXG_RST  = 31'h7FFF_FFFF;

    // paddr[2] selects the register
    localparam logic REG_STEP_DELAY = 1'b0;
    localparam logic REG_MAX_GOAL   = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK = 2'd0,
        KIND_HOME = 2'd1,
        KIND_GOAL = 2'd2,
        KIND_STOP = 2'd3
    } t_kind;

    typedef struct packed {
        logic                 accepted;
        logic                 is_homing;
        logic                 is_calibrated;
        logic                 is_running;
        logic [OUT_POS_W-1:0] position;
        logic [COIL_W-1:0]    coil_pattern;
    } t_result;

    localparam logic [COIL_W-1:0] COIL_OFF = 4'h0;

    // full-step phase: P1|P3, P2|P3, P2|P4, P4|P1
    function automatic logic [COIL_W-1:0] phase_coil(input logic [1:0] ph);
        logic [COIL_W-1:0] c;
        case (ph)
            2'd0: c = 4'h5;
            2'd1: c = 4'h6;
            2'd2: c = 4'hA;
            2'd3: c = 4'h9;
            default: c = COIL_OFF;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/sihm_cfg_regs.sv
module sihm_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sihm_pkg::APB_AW-1:0]   paddr,
    input  logic [sihm_pkg::APB_DW-1:0]   pwdata,
    output logic [sihm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output logic [sihm_pkg::DELAY_W-1:0]  o_step_delay,
    output logic [sihm_pkg::MAXG_W-1:0]   o_max_goal
);

    logic [sihm_pkg::DELAY_W-1:0] r_step_delay;
    logic [sihm_pkg::MAXG_W-1:0]  r_max_goal;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_delay <= sihm_pkg::DELAY_RST;
            r_max_goal   <= sihm_pkg::MAXG_RST;
        end else if (wr_en) begin
            if (paddr[2] == sihm_pkg::REG_STEP_DELAY) begin
                r_step_delay <= pwdata[sihm_pkg::DELAY_W-1:0];
            end else begin
                r_max_goal <= pwdata[sihm_pkg::MAXG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == sihm_pkg::REG_STEP_DELAY) begin
            prdata = sihm_pkg::APB_DW'(r_step_delay);
        end else begin
            prdata = sihm_pkg::APB_DW'(r_max_goal);
        end
    end

    assign o_step_delay = r_step_delay;
    assign o_max_goal   = r_max_goal;

endmodule

// File: rtl/sihm_core.sv
`include "stepper_indexer_with_homing_top_defines.svh"

module sihm_core #(
    parameter int POSITION_WIDTH = 32,
    parameter int TICK_WIDTH     = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [sihm_pkg::KIND_W-1:0]   i_kind,
    input  logic                          i_limit_level,
    input  logic [sihm_pkg::GOAL_W-1:0]   i_goal,
    input  logic [sihm_pkg::DELAY_W-1:0]  i_step_delay,
    input  logic [sihm_pkg::MAXG_W-1:0]   i_max_goal,
    output sihm_pkg::t_result             o_res
);

    localparam int CMP_W = (TICK_WIDTH > sihm_pkg::DELAY_W) ? TICK_WIDTH : sihm_pkg::DELAY_W;

    logic [POSITION_WIDTH-1:0]     r_pos, n_pos;
    logic [POSITION_WIDTH-1:0]     r_goal, n_goal;
    logic [TICK_WIDTH-1:0]         r_tick, n_tick;
    logic                          r_run, n_run;
    logic                          r_cal, n_cal;
    logic                          r_hom, n_hom;
    logic                          r_tmr, n_tmr;
    logic [sihm_pkg::COIL_W-1:0]   r_coil, n_coil;

    logic [TICK_WIDTH-1:0]         tick_inc;
    logic [POSITION_WIDTH-1:0]     diff;
    logic [POSITION_WIDTH-1:0]     pos_a;
    logic                          acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_goal <= '0;
            r_tick <= '0;
            r_run  <= 1'b0;
            r_cal  <= 1'b0;
            r_hom  <= 1'b0;
            r_tmr  <= 1'b0;
            r_coil <= sihm_pkg::COIL_OFF;
        end else if (i_go) begin
            r_pos  <= n_pos;
            r_goal <= n_goal;
            r_tick <= n_tick;
            r_run  <= n_run;
            r_cal  <= n_cal;
            r_hom  <= n_hom;
            r_tmr  <= n_tmr;
            r_coil <= n_coil;
        end
    end

    assign tick_inc = (r_tick == '1) ? r_tick : r_tick + 1'b1;
    assign diff     = r_goal - r_pos;

    always_comb begin
        n_pos  = r_pos;
        n_goal = r_goal;
        n_tick = r_tick;
        n_run  = r_run;
        n_cal  = r_cal;
        n_hom  = r_hom;
        n_tmr  = r_tmr;
        n_coil = r_coil;
        pos_a  = r_pos;
        acc    = 1'b1;
        case (sihm_pkg::t_kind'(i_kind))
            sihm_pkg::KIND_TICK: begin
                if (r_tmr) begin
                    n_tick = tick_inc;
                    if ((CMP_W'(tick_inc) >= CMP_W'(i_step_delay)) && r_cal) begin
                        n_tick = '0;
                        if (diff != '0) begin
                            n_run = 1'b1;
                            pos_a = diff[POSITION_WIDTH-1] ? r_pos - 1'b1 : r_pos + 1'b1;
                            n_coil = sihm_pkg::phase_coil(pos_a[1:0]);
                        end else begin
                            n_coil = sihm_pkg::COIL_OFF;
                            n_run  = 1'b0;
                            n_tmr  = 1'b0;
                        end
                    end
                    n_pos = pos_a;
                    if (r_hom) begin
                        n_run  = 1'b1;
                        n_coil = sihm_pkg::phase_coil(pos_a[1:0]);
                        n_pos  = pos_a - 1'b1;
                        if (!i_limit_level) begin
                            n_coil = sihm_pkg::COIL_OFF;
                            n_pos  = '0;
                            n_cal  = 1'b1;
                            n_run  = 1'b0;
                            n_hom  = 1'b0;
                            n_tick = '0;
                            n_tmr  = 1'b0;
                        end
                    end
                end
            end
            sihm_pkg::KIND_HOME: begin
                n_cal = 1'b0;
                n_hom = 1'b1;
                n_run = 1'b1;
                n_tmr = 1'b1;
            end
            sihm_pkg::KIND_GOAL: begin
                if ((i_goal > i_max_goal) || r_run || !r_cal) begin
                    acc = 1'b0;
                end else begin
                    n_goal = POSITION_WIDTH'(i_goal);
                    n_tmr  = 1'b1;
                end
            end
            sihm_pkg::KIND_STOP: begin
                n_coil = sihm_pkg::COIL_OFF;
                n_tmr  = 1'b0;
            end
            default: begin
                acc = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_res.coil_pattern  = n_coil;
        o_res.position      = sihm_pkg::OUT_POS_W'($signed(n_pos));
        o_res.is_running    = n_run;
        o_res.is_calibrated = n_cal;
        o_res.is_homing     = n_hom;
        o_res.accepted      = acc;
    end

    `SIHM_ASSERT_NEVER(a_hom_and_cal, i_clk, i_rst_n, r_hom && r_cal)
    `SIHM_ASSERT_IMPLIES(a_hom_runs, i_clk, i_rst_n, r_hom, r_run)
    `SIHM_ASSERT_IMPLIES(a_cal_clear, i_clk, i_rst_n, $fell(r_cal),
        $past(i_go) && ($past(i_kind) == sihm_pkg::KIND_HOME))
    `SIHM_ASSERT_IMPLIES(a_reject_goal, i_clk, i_rst_n, i_go && !acc,
        i_kind == sihm_pkg::KIND_GOAL)

endmodule

// File: rtl/stepper_indexer_with_homing_top.sv
// Channel  | Dir | Handshake          | Payload
// s_*      | in  | s_tvalid/s_tready  | tuser: kind; tdata: limit_level, goal
// m_*      | out | m_tvalid/m_tready  | tdata: coil, position, flags, accepted
// APB      | in  | psel/penable/pready| step_delay @0x0, max_goal @0x4
//
// One transaction per cycle sustained while m_tready is high; from s_ to m_
// the path runs through the input register, then state update into the result register.
// Synchronous active-low reset; no clearing pass.
// A stalled m_ side holds the result and the next item in the input register.
`include "stepper_indexer_with_homing_top_defines.svh"

module stepper_indexer_with_homing_top #(
    parameter int POSITION_WIDTH = 32,
    parameter int TICK_WIDTH     = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,  // limit_level, goal[30:0]
    input  logic [1:0]                   s_tuser,  // kind
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // coil_pattern[3:0], position[31:0], is_running, is_calibrated, is_homing, accepted
    output logic [39:0]                  m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sihm_pkg::APB_AW-1:0]  paddr,
    input  logic [sihm_pkg::APB_DW-1:0]  pwdata,
    output logic [sihm_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    logic                          r_in_valid;
    logic [sihm_pkg::KIND_W-1:0]   r_in_kind;
    logic                          r_in_limit;
    logic [sihm_pkg::GOAL_W-1:0]   r_in_goal;
    logic                          r_out_valid;
    sihm_pkg::t_result             r_out;
    sihm_pkg::t_result             res;
    logic                          core_go;
    logic [sihm_pkg::DELAY_W-1:0]  step_delay;
    logic [sihm_pkg::MAXG_W-1:0]   max_goal;

    sihm_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_step_delay (step_delay),
        .o_max_goal   (max_goal)
    );

    assign core_go  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || core_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_kind  <= s_tuser;
            r_in_limit <= s_tdata[0];
            r_in_goal  <= s_tdata[31:1];
        end
    end

    sihm_core #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .TICK_WIDTH     (TICK_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (core_go),
        .i_kind        (r_in_kind),
        .i_limit_level (r_in_limit),
        .i_goal        (r_in_goal),
        .i_step_delay  (step_delay),
        .i_max_goal    (max_goal),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_go) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_go) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out;

    `SIHM_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !core_go, r_in_valid)
    `SIHM_ASSERT_NEXT(a_out_fill, i_clk, i_rst_n, core_go, r_out_valid)
    `SIHM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule
